### hdl/assert_macros.svh
// assertion helpers shared by the checker files
// the macros expect clock in the calling scope, and all but the last reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define PFA_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pfa check failed");

// next-cycle implication, disabled while reset is high
`define PFA_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pfa check failed");

// next-cycle implication that also holds across reset
`define PFA_ASSERT_ALWAYS_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("pfa check failed");

`endif

### hdl/pfa_pkg.sv
// ----------------------------------------------------------------------------
// pfa_pkg
// Shared constants, codes and types of the page frame allocator.
// ----------------------------------------------------------------------------
package pfa_pkg;

   localparam int PAGE_SIZE  = 4096;
   localparam int MAX_PAGES  = 4096;
   localparam int ADDR_W     = 32;
   localparam int PAGE_SHIFT = $clog2(PAGE_SIZE);
   localparam int PFN_W      = ADDR_W - PAGE_SHIFT;
   localparam int IDX_W      = $clog2(MAX_PAGES);
   localparam int COUNT_W    = IDX_W + 1;
   localparam int ROW_PAGES  = 64;
   localparam int LANE_W     = $clog2(ROW_PAGES);
   localparam int ROW_W      = IDX_W - LANE_W;
   localparam int ROWS       = MAX_PAGES / ROW_PAGES;
   localparam int MARK_W     = 2;
   localparam int ROW_BITS   = ROW_PAGES * MARK_W;
   localparam int REQ_W      = 3;
   localparam int STATUS_W   = 2;

   typedef logic [MARK_W-1:0] mark_type;

   localparam mark_type MARK_RESERVED = 2'd0;
   localparam mark_type MARK_FREE     = 2'd1;
   localparam mark_type MARK_ALLOC    = 2'd2;

   typedef enum logic [REQ_W-1:0] {
      REQ_INIT,
      REQ_MARK_FREE,
      REQ_MARK_RESERVED,
      REQ_ALLOCATE,
      REQ_CLAIM,
      REQ_FREE,
      REQ_LOOKUP,
      REQ_UNUSED
   } req_code_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK,
      STATUS_NO_PAGE,
      STATUS_REFUSED,
      STATUS_NO_FREE
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_RANGE,
      ST_READ,
      ST_MODIFY,
      ST_COUNT,
      ST_FINISH
   } fsm_state_type;

   typedef enum logic [1:0] {
      ROW_SET_RANGE,
      ROW_ALLOC,
      ROW_SINGLE
   } row_mode_type;

   typedef struct packed {
      row_mode_type        mode;
      mark_type            target;
      logic [LANE_W-1:0]   lo_off;
      logic [LANE_W-1:0]   hi_off;
      logic [LANE_W-1:0]   lane;
      logic [LANE_W:0]     lim_off;
   } row_ctl_type;

   typedef struct packed {
      logic                found;
      logic [LANE_W-1:0]   found_lane;
      mark_type            lane_mark;
   } row_stat_type;

endpackage

### hdl/pfa_channels.sv
// ----------------------------------------------------------------------------
// pfa channels
// Valid/ready channel bundles for requests, responses and the csr write.
// ----------------------------------------------------------------------------
interface pfa_req_if;
   import pfa_pkg::*;

   logic                valid;
   logic                ready;
   logic [REQ_W-1:0]    req_type;
   logic [ADDR_W-1:0]   start_address;
   logic [ADDR_W-1:0]   end_address;
   logic [ADDR_W-1:0]   page_address;

   modport source (output valid, req_type, start_address, end_address, page_address,
                   input ready);
   modport sink   (input valid, req_type, start_address, end_address, page_address,
                   output ready);
endinterface

interface pfa_rsp_if;
   import pfa_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [IDX_W-1:0]    page_index;
   logic [ADDR_W-1:0]   page_base;
   logic [MARK_W-1:0]   page_state;
   logic [COUNT_W-1:0]  free_count;

   modport source (output valid, status, page_index, page_base, page_state, free_count,
                   input ready);
   modport sink   (input valid, status, page_index, page_base, page_state, free_count,
                   output ready);
endinterface

interface pfa_csr_if;
   import pfa_pkg::*;

   logic                valid;
   logic                ready;
   logic [COUNT_W-1:0]  page_limit;

   modport source (output valid, page_limit, input ready);
   modport sink   (input valid, page_limit, output ready);
endinterface

### hdl/pfa_page_mem.sv
// ----------------------------------------------------------------------------
// pfa_page_mem
// Page mark memory, one row of 64 two-bit marks per address, with row valid
// bits so that an unwritten or cleared row reads as all reserved.
// ----------------------------------------------------------------------------
module pfa_page_mem (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          clear,
   input  logic [pfa_pkg::ROW_W-1:0]     rd_addr,
   output logic [pfa_pkg::ROW_BITS-1:0]  rd_data,
   input  logic                          wr_en,
   input  logic [pfa_pkg::ROW_W-1:0]     wr_addr,
   input  logic [pfa_pkg::ROW_BITS-1:0]  wr_data
);
   import pfa_pkg::*;

   logic [ROW_BITS-1:0] mem_ff [ROWS];
   logic [ROW_BITS-1:0] rd_data_ff;
   logic [ROWS-1:0]     valid_ff;
   logic                rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

### hdl/pfa_row_unit.sv
// ----------------------------------------------------------------------------
// pfa_row_unit
// Shared row unit: rewrites one row of page marks for a range mark (and flags
// its free-state changes), an allocate search or a single page update.
// ----------------------------------------------------------------------------
module pfa_row_unit (
   input  pfa_pkg::row_ctl_type          ctl,
   input  logic [pfa_pkg::ROW_BITS-1:0]  old_row,
   output logic [pfa_pkg::ROW_BITS-1:0]  new_row,
   output logic [pfa_pkg::ROW_PAGES-1:0] flags,
   output pfa_pkg::row_stat_type         stat
);
   import pfa_pkg::*;

   mark_type             old_mark [ROW_PAGES];
   logic [ROW_PAGES-1:0] sel;
   logic [ROW_PAGES-1:0] elig;
   logic                 found;
   logic [LANE_W-1:0]    found_lane;

   always_comb begin
      for (int j = 0; j < ROW_PAGES; j++) begin
         old_mark[j] = old_row[j*MARK_W +: MARK_W];
         sel[j]      = (LANE_W'(j) >= ctl.lo_off) && (LANE_W'(j) <= ctl.hi_off);
         elig[j]     = (old_mark[j] == MARK_FREE) && ((LANE_W+1)'(j) < ctl.lim_off);
      end
   end

   // lowest eligible lane wins
   always_comb begin
      found      = 1'b0;
      found_lane = '0;
      for (int j = ROW_PAGES - 1; j >= 0; j--) begin
         if (elig[j]) begin
            found      = 1'b1;
            found_lane = LANE_W'(j);
         end
      end
   end

   always_comb begin
      new_row         = old_row;
      flags           = '0;
      stat.found      = found;
      stat.found_lane = found_lane;
      stat.lane_mark  = old_mark[ctl.lane];
      unique case (ctl.mode)
         ROW_SET_RANGE: begin
            for (int j = 0; j < ROW_PAGES; j++) begin
               if (sel[j]) begin
                  new_row[j*MARK_W +: MARK_W] = ctl.target;
                  flags[j] = (old_mark[j] == MARK_FREE) != (ctl.target == MARK_FREE);
               end
            end
         end
         ROW_ALLOC: begin
            if (found) begin
               new_row[found_lane*MARK_W +: MARK_W] = MARK_ALLOC;
            end
         end
         ROW_SINGLE: begin
            if (old_mark[ctl.lane] != MARK_RESERVED) begin
               new_row[ctl.lane*MARK_W +: MARK_W] = ctl.target;
            end
         end
         default: begin
         end
      endcase
   end

endmodule

### hdl/pfa_popcount.sv
// ----------------------------------------------------------------------------
// pfa_popcount
// Adder tree counting the changed pages of one row.
// ----------------------------------------------------------------------------
module pfa_popcount (
   input  logic [pfa_pkg::ROW_PAGES-1:0] flags,
   output logic [pfa_pkg::LANE_W:0]      count
);
   import pfa_pkg::*;

   logic [1:0] lvl1 [32];
   logic [2:0] lvl2 [16];
   logic [3:0] lvl3 [8];
   logic [4:0] lvl4 [4];
   logic [5:0] lvl5 [2];

   always_comb begin
      for (int j = 0; j < 32; j++) begin
         lvl1[j] = 2'(flags[2*j]) + 2'(flags[2*j+1]);
      end
      for (int j = 0; j < 16; j++) begin
         lvl2[j] = 3'(lvl1[2*j]) + 3'(lvl1[2*j+1]);
      end
      for (int j = 0; j < 8; j++) begin
         lvl3[j] = 4'(lvl2[2*j]) + 4'(lvl2[2*j+1]);
      end
      for (int j = 0; j < 4; j++) begin
         lvl4[j] = 5'(lvl3[2*j]) + 5'(lvl3[2*j+1]);
      end
      for (int j = 0; j < 2; j++) begin
         lvl5[j] = 6'(lvl4[2*j]) + 6'(lvl4[2*j+1]);
      end
      count = (LANE_W+1)'(lvl5[0]) + (LANE_W+1)'(lvl5[1]);
   end

endmodule

### hdl/page_frame_allocator_unit.sv
// ----------------------------------------------------------------------------
// page_frame_allocator_unit
// Bitmap page frame allocator with a three-state mark per page and a count
// of free pages, driven by a row sequencer over rows of 64 page marks.
// ----------------------------------------------------------------------------
// usage
//   req_chan takes one request at a time (init, mark free range, mark
//   reserved range, allocate, claim, free, lookup); rsp_chan returns exactly
//   one response per request, in order. csr_chan writes the page limit and is
//   always ready; write it only while no request is in flight.
//   each request runs a prep step; init, unused codes and out-of-range
//   pages then go straight to the finish step, and an empty range goes there
//   from its range step. Claim, free and lookup each visit a single row;
//   allocate scans up to 64 rows until it finds a free page; range marks
//   read, rewrite and count each touched row, up to 64. The next request
//   can be taken in the cycle after the response load. The single shared
//   row unit and the mark memory, whose ports share one row address, handle
//   the rows in turn: each is read, rewritten and (for ranges) counted.
//   req_chan.ready is high only while the sequencer is idle; a finished
//   response sits in an output register, so the next request is taken even
//   while rsp_chan is stalled. If a second response is due before the first
//   is taken, the sequencer waits in its finish step.
//   reset marks every page reserved, zeroes the free count and page limit.
// ----------------------------------------------------------------------------
module page_frame_allocator_unit (
   input  logic         clock,
   input  logic         reset,
   pfa_req_if.sink      req_chan,
   pfa_rsp_if.source    rsp_chan,
   pfa_csr_if.sink      csr_chan
);
   import pfa_pkg::*;

   localparam logic [ADDR_W-1:0] PAGE_MASK = ADDR_W'(PAGE_SIZE - 1);

   fsm_state_type        state_ff, state_in;
   req_code_type         op_ff, op_in;
   logic [ADDR_W-1:0]    sa_ff, sa_in, ea_ff, ea_in, pa_ff, pa_in;
   logic [ADDR_W-1:0]    s_round_ff, s_round_in, e_round_ff, e_round_in;
   logic                 span_ok_ff, span_ok_in;
   logic [IDX_W-1:0]     first_ff, first_in, last_ff, last_in;
   logic [ROW_W-1:0]     row_ff, row_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic                 have_ff, have_in;
   mark_type             mark_ff, mark_in;
   status_type           status_ff, status_in;
   logic [ROW_PAGES-1:0] flags_ff, flags_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [COUNT_W-1:0]   total_ff, total_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic [IDX_W-1:0]     rsp_index_ff, rsp_index_in;
   logic [ADDR_W-1:0]    rsp_base_ff, rsp_base_in;
   mark_type             rsp_state_ff, rsp_state_in;
   logic [COUNT_W-1:0]   rsp_count_ff, rsp_count_in;

   logic                 req_accept;
   logic                 rsp_load;
   logic [COUNT_W-1:0]   lim;
   logic [PFN_W-1:0]     pa_pfn;
   logic                 pa_oob;
   logic [PFN_W-1:0]     first_pfn, lastx_pfn, limited, limited_m1;
   logic                 range_empty;
   logic [ROW_W:0]       next_row;
   logic                 alloc_more;
   logic                 last_row;

   row_ctl_type          ctl;
   row_stat_type         stat;
   logic [ROW_BITS-1:0]  old_row, new_row;
   logic [ROW_PAGES-1:0] row_flags;
   logic [LANE_W:0]      pop;
   logic                 mem_wr_en;
   logic                 mem_clear;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign csr_chan.ready = 1'b1;
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign rsp_load       = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_chan.ready);

   assign lim    = (total_ff > COUNT_W'(MAX_PAGES)) ? COUNT_W'(MAX_PAGES) : total_ff;
   assign pa_pfn = pa_ff[ADDR_W-1:PAGE_SHIFT];
   assign pa_oob = pa_pfn >= PFN_W'(lim);

   // range bounds in pages, clipped to the managed page count
   assign first_pfn   = s_round_ff[ADDR_W-1:PAGE_SHIFT];
   assign lastx_pfn   = e_round_ff[ADDR_W-1:PAGE_SHIFT];
   assign limited     = (lastx_pfn < PFN_W'(lim)) ? lastx_pfn : PFN_W'(lim);
   assign limited_m1  = limited - PFN_W'(1);
   assign range_empty = !span_ok_ff || (s_round_ff >= e_round_ff) || (first_pfn >= limited);

   assign next_row   = {1'b0, row_ff} + (ROW_W+1)'(1);
   assign alloc_more = {next_row, LANE_W'(0)} < lim;
   assign last_row   = (row_ff == last_ff[IDX_W-1:LANE_W]);

   // row unit control
   always_comb begin
      ctl.lo_off  = (row_ff == first_ff[IDX_W-1:LANE_W]) ? first_ff[LANE_W-1:0] : '0;
      ctl.hi_off  = last_row ? last_ff[LANE_W-1:0] : '1;
      ctl.lane    = idx_ff[LANE_W-1:0];
      ctl.lim_off = ({1'b0, row_ff} < lim[COUNT_W-1:LANE_W]) ?
                    (LANE_W+1)'(ROW_PAGES) : {1'b0, lim[LANE_W-1:0]};
      unique case (op_ff)
         REQ_MARK_FREE: begin
            ctl.mode   = ROW_SET_RANGE;
            ctl.target = MARK_FREE;
         end
         REQ_MARK_RESERVED: begin
            ctl.mode   = ROW_SET_RANGE;
            ctl.target = MARK_RESERVED;
         end
         REQ_ALLOCATE: begin
            ctl.mode   = ROW_ALLOC;
            ctl.target = MARK_ALLOC;
         end
         REQ_CLAIM: begin
            ctl.mode   = ROW_SINGLE;
            ctl.target = MARK_ALLOC;
         end
         REQ_FREE: begin
            ctl.mode   = ROW_SINGLE;
            ctl.target = MARK_FREE;
         end
         default: begin
            ctl.mode   = ROW_SINGLE;
            ctl.target = MARK_RESERVED;
         end
      endcase
   end

   pfa_page_mem u_page_mem (
      .clock   (clock),
      .reset   (reset),
      .clear   (mem_clear),
      .rd_addr (row_ff),
      .rd_data (old_row),
      .wr_en   (mem_wr_en),
      .wr_addr (row_ff),
      .wr_data (new_row)
   );

   pfa_row_unit u_row_unit (
      .ctl     (ctl),
      .old_row (old_row),
      .new_row (new_row),
      .flags   (row_flags),
      .stat    (stat)
   );

   pfa_popcount u_popcount (
      .flags (flags_ff),
      .count (pop)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            unique case (op_ff)
               REQ_MARK_FREE, REQ_MARK_RESERVED: state_in = ST_RANGE;
               REQ_ALLOCATE: state_in = (lim == '0) ? ST_FINISH : ST_READ;
               REQ_CLAIM, REQ_FREE, REQ_LOOKUP: state_in = pa_oob ? ST_FINISH : ST_READ;
               default: state_in = ST_FINISH;
            endcase
         end
         ST_RANGE: begin
            state_in = range_empty ? ST_FINISH : ST_READ;
         end
         ST_READ: begin
            state_in = ST_MODIFY;
         end
         ST_MODIFY: begin
            priority case (op_ff)
               REQ_MARK_FREE, REQ_MARK_RESERVED: state_in = ST_COUNT;
               REQ_ALLOCATE: begin
                  state_in = (!stat.found && alloc_more) ? ST_READ : ST_FINISH;
               end
               default: state_in = ST_FINISH;
            endcase
         end
         ST_COUNT: begin
            state_in = last_row ? ST_FINISH : ST_READ;
         end
         ST_FINISH: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      op_in         = op_ff;
      sa_in         = sa_ff;
      ea_in         = ea_ff;
      pa_in         = pa_ff;
      s_round_in    = s_round_ff;
      e_round_in    = e_round_ff;
      span_ok_in    = span_ok_ff;
      first_in      = first_ff;
      last_in       = last_ff;
      row_in        = row_ff;
      idx_in        = idx_ff;
      have_in       = have_ff;
      mark_in       = mark_ff;
      status_in     = status_ff;
      flags_in      = flags_ff;
      count_in      = count_ff;
      total_in      = total_ff;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_base_in   = rsp_base_ff;
      rsp_state_in  = rsp_state_ff;
      rsp_count_in  = rsp_count_ff;
      mem_wr_en     = 1'b0;
      mem_clear     = 1'b0;

      if (csr_chan.valid) begin
         total_in = csr_chan.page_limit;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               op_in = req_code_type'(req_chan.req_type);
               sa_in = req_chan.start_address;
               ea_in = req_chan.end_address;
               pa_in = req_chan.page_address;
            end
         end
         ST_PREP: begin
            status_in = STATUS_OK;
            have_in   = 1'b0;
            idx_in    = '0;
            mark_in   = MARK_RESERVED;
            unique case (op_ff)
               REQ_INIT: begin
                  mem_clear = 1'b1;
                  count_in  = '0;
               end
               REQ_MARK_FREE: begin
                  // inward rounding
                  s_round_in = (sa_ff + PAGE_MASK) & ~PAGE_MASK;
                  e_round_in = ea_ff & ~PAGE_MASK;
                  span_ok_in = sa_ff < ea_ff;
               end
               REQ_MARK_RESERVED: begin
                  // outward rounding, may wrap to zero
                  s_round_in = sa_ff & ~PAGE_MASK;
                  e_round_in = (ea_ff + PAGE_MASK) & ~PAGE_MASK;
                  span_ok_in = sa_ff < ea_ff;
               end
               REQ_ALLOCATE: begin
                  row_in = '0;
                  if (lim == '0) begin
                     status_in = STATUS_NO_FREE;
                  end
               end
               REQ_CLAIM, REQ_FREE, REQ_LOOKUP: begin
                  if (pa_oob) begin
                     status_in = STATUS_NO_PAGE;
                  end else begin
                     idx_in  = pa_pfn[IDX_W-1:0];
                     row_in  = pa_pfn[IDX_W-1:LANE_W];
                     have_in = 1'b1;
                  end
               end
               REQ_UNUSED: begin
               end
               default: begin
               end
            endcase
         end
         ST_RANGE: begin
            first_in = first_pfn[IDX_W-1:0];
            last_in  = limited_m1[IDX_W-1:0];
            row_in   = first_pfn[IDX_W-1:LANE_W];
         end
         ST_READ: begin
         end
         ST_MODIFY: begin
            unique case (op_ff)
               REQ_MARK_FREE, REQ_MARK_RESERVED: begin
                  mem_wr_en = 1'b1;
                  flags_in  = row_flags;
               end
               REQ_ALLOCATE: begin
                  if (stat.found) begin
                     mem_wr_en = 1'b1;
                     count_in  = count_ff - COUNT_W'(1);
                     idx_in    = {row_ff, stat.found_lane};
                     have_in   = 1'b1;
                     mark_in   = MARK_ALLOC;
                  end else if (alloc_more) begin
                     row_in = next_row[ROW_W-1:0];
                  end else begin
                     status_in = STATUS_NO_FREE;
                  end
               end
               REQ_CLAIM: begin
                  if (stat.lane_mark == MARK_RESERVED) begin
                     status_in = STATUS_REFUSED;
                     mark_in   = MARK_RESERVED;
                  end else begin
                     mem_wr_en = 1'b1;
                     mark_in   = MARK_ALLOC;
                     if (stat.lane_mark == MARK_FREE) begin
                        count_in = count_ff - COUNT_W'(1);
                     end
                  end
               end
               REQ_FREE: begin
                  if (stat.lane_mark == MARK_RESERVED) begin
                     status_in = STATUS_REFUSED;
                     mark_in   = MARK_RESERVED;
                  end else begin
                     mem_wr_en = 1'b1;
                     mark_in   = MARK_FREE;
                     if (stat.lane_mark != MARK_FREE) begin
                        count_in = count_ff + COUNT_W'(1);
                     end
                  end
               end
               default: begin
                  mark_in = stat.lane_mark;
               end
            endcase
         end
         ST_COUNT: begin
            if (op_ff == REQ_MARK_FREE) begin
               count_in = count_ff + COUNT_W'(pop);
            end else begin
               count_in = count_ff - COUNT_W'(pop);
            end
            row_in = next_row[ROW_W-1:0];
         end
         ST_FINISH: begin
            if (rsp_load) begin
               rsp_status_in = status_ff;
               rsp_index_in  = have_ff ? idx_ff : '0;
               rsp_base_in   = have_ff ? (ADDR_W'(idx_ff) << PAGE_SHIFT) : '0;
               rsp_state_in  = have_ff ? mark_ff : MARK_RESERVED;
               rsp_count_in  = count_ff;
            end
         end
         default: begin
         end
      endcase

      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         total_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         total_ff     <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      sa_ff         <= sa_in;
      ea_ff         <= ea_in;
      pa_ff         <= pa_in;
      s_round_ff    <= s_round_in;
      e_round_ff    <= e_round_in;
      span_ok_ff    <= span_ok_in;
      first_ff      <= first_in;
      last_ff       <= last_in;
      row_ff        <= row_in;
      idx_ff        <= idx_in;
      have_ff       <= have_in;
      mark_ff       <= mark_in;
      status_ff     <= status_in;
      flags_ff      <= flags_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_base_ff   <= rsp_base_in;
      rsp_state_ff  <= rsp_state_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.status     = rsp_status_ff;
   assign rsp_chan.page_index = rsp_index_ff;
   assign rsp_chan.page_base  = rsp_base_ff;
   assign rsp_chan.page_state = rsp_state_ff;
   assign rsp_chan.free_count = rsp_count_ff;

endmodule

### hdl/pfa_checker.sv
// ----------------------------------------------------------------------------
// pfa_checker
// Port-level checks of the page frame allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pfa_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [pfa_pkg::STATUS_W-1:0]  rsp_status,
   input  logic [pfa_pkg::IDX_W-1:0]     rsp_page_index,
   input  logic [pfa_pkg::ADDR_W-1:0]    rsp_page_base,
   input  logic [pfa_pkg::MARK_W-1:0]    rsp_page_state,
   input  logic [pfa_pkg::COUNT_W-1:0]   rsp_free_count
);
   import pfa_pkg::*;

   // a stalled response stays up
   `PFA_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)

   // out of reset: idle and nothing pending
   `PFA_ASSERT_ALWAYS_NEXT(a_reset_idle, reset, !rsp_valid && req_ready)

   // one request in flight at a time
   `PFA_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready)

   // no page concerned means zeroed page fields
   `PFA_ASSERT_NOW(a_empty_fields, rsp_valid && (rsp_status == STATUS_NO_PAGE || rsp_status == STATUS_NO_FREE), rsp_page_index == '0 && rsp_page_base == '0 && rsp_page_state == '0)

   `PFA_ASSERT_NOW(a_count_bound, rsp_valid, rsp_free_count <= COUNT_W'(MAX_PAGES))

endmodule

bind page_frame_allocator_unit pfa_checker u_pfa_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_status     (rsp_chan.status),
   .rsp_page_index (rsp_chan.page_index),
   .rsp_page_base  (rsp_chan.page_base),
   .rsp_page_state (rsp_chan.page_state),
   .rsp_free_count (rsp_chan.free_count)
);
